FILE: rtl/sinr_pkg.sv
// sinr_pkg: widths, register indexes, phase codes and constants shared by the
// sine ramp motion profile block. no dependencies.
`timescale 1ns / 1ps

package sinr_pkg;

   localparam int POS_W   = 32;
   localparam int DIST_W  = 31;
   localparam int SPD_W   = 16;
   localparam int OUT_W   = 24;
   localparam int COS_W   = 16;
   localparam int FAC_W   = 17;
   localparam int PROD_W  = SPD_W + FAC_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_DIST   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SPD  = 2'd2;

   // phase codes of a result beat
   localparam logic [1:0] PH_ACCEL  = 2'd0;
   localparam logic [1:0] PH_CRUISE = 2'd1;
   localparam logic [1:0] PH_BRAKE  = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   // pi in Q2.30, used to build the cosine table
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam logic [OUT_W-1:0] SPEED_MAX = 24'hFF_FFFF;
   localparam logic [OUT_W-1:0] SPEED_MIN = 24'd256;

   typedef logic [1:0] phase_type;

endpackage

FILE: rtl/sinr_if.sv
// sinr_if: valid/ready channel interfaces for the request, response and csr
// sides of the motion profile block. depends on sinr_pkg.
`timescale 1ns / 1ps

interface sinr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sinr_pkg::POS_W-1:0]   position;
   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

interface sinr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sinr_pkg::OUT_W-1:0]          speed_q8;
   logic [1:0]                          phase;
   modport source (output valid, output speed_q8, output phase, input ready);
   modport sink   (input valid, input speed_q8, input phase, output ready);
endinterface

interface sinr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sinr_pkg::CSR_IDX_W-1:0]      index;
   logic [sinr_pkg::CSR_DAT_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sine_ramp_motion_profile.sv
// sine_ramp_motion_profile: one commanded speed (Q16.8) and phase per encoder
// position beat. An accelerate or brake beat goes through abs, phase decision, argument,
// the serial divider that forms the cosine angle index one quotient bit per cycle,
// cosine table read and multiply; cruise and done beats go from the phase decision
// straight to the final step, which loads the response register and waits while an
// earlier response is still held there. The block takes one request at a time and is
// ready again once the result is loaded into the response register. COS_TABLE_DEPTH
// must be a power of two.
// depends on sinr_pkg, sinr_if, sinr_div and sinr_cos_rom.
`timescale 1ns / 1ps

module sine_ramp_motion_profile #(
   parameter int COS_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   sinr_req_if.sink    req_bus,
   sinr_rsp_if.source  rsp_bus,
   sinr_csr_if.sink    csr_bus
);
   import sinr_pkg::*;

   localparam int IDX_W   = $clog2(COS_TABLE_DEPTH);
   localparam int SHIFT_W = IDX_W + 1;
   localparam int QUO_W   = IDX_W + 2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ABS   = 3'd1;
   localparam logic [2:0] S_PHASE = 3'd2;
   localparam logic [2:0] S_ARG   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_ROM   = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]         m_ff, m_in;
   phase_type                phase_ff, phase_in;
   logic [FAC_W-1:0]         factor_ff, factor_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [POS_W-1:0]  start_ff, start_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [SPD_W-1:0]         tspeed_ff, tspeed_in;
   logic [POS_W-1:0]         ramp_ff, ramp_in;
   logic [OUT_W-1:0]         last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]         rsp_speed_ff, rsp_speed_in;
   phase_type                rsp_phase_ff, rsp_phase_in;

   logic                     div_start;
   logic                     div_busy;
   logic [QUO_W-1:0]         quo;
   logic [DIST_W-1:0]        div_arg;
   logic [IDX_W-1:0]         rom_addr;
   logic [COS_W-1:0]         rom_data;

   logic signed [POS_W:0]    delta;
   logic [POS_W:0]           brake_arg;
   logic [DIST_W-1:0]        remain;
   logic [1:0]               quad;
   logic [IDX_W-1:0]         frac;
   logic [COS_W-1:0]         cos_mag;
   logic                     cos_add;
   logic [PROD_W:0]          rounded;
   logic [PROD_W-9:0]        scaled;
   logic [OUT_W-1:0]         curve_spd;
   logic [OUT_W-1:0]         fin_spd;
   logic                     req_take;
   logic                     csr_take;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_take      = csr_bus.valid && csr_bus.ready;

   assign delta     = {pos_ff[POS_W-1], pos_ff} - {start_ff[POS_W-1], start_ff};
   assign remain    = dist_ff - m_ff[DIST_W-1:0];
   assign brake_arg = {1'b0, m_ff} + {1'b0, ramp_ff} - {2'b00, dist_ff};
   assign div_arg   = (phase_ff == PH_ACCEL) ? m_ff[DIST_W-1:0] : brake_arg[DIST_W-1:0];
   assign div_start = (state_ff == S_ARG);

   // quadrant select: odd quadrants read the mirrored entry
   assign quad     = quo[QUO_W-1:QUO_W-2];
   assign frac     = quo[IDX_W-1:0];
   assign rom_addr = quad[0] ? (IDX_W'(0) - frac) : frac;
   assign cos_mag  = (quad[0] && frac == '0) ? '0 : rom_data;
   // cosine is negative in the middle quadrants; accel uses 1 - cos
   assign cos_add  = ((quad == 2'd1) || (quad == 2'd2)) == (phase_ff == PH_ACCEL);

   assign rounded   = {1'b0, prod_ff} + (PROD_W + 1)'(256);
   assign scaled    = rounded[PROD_W:9];
   assign curve_spd = (scaled > (PROD_W - 8)'(SPEED_MAX)) ? SPEED_MAX : OUT_W'(scaled);

   always_comb begin
      case (phase_ff)
         PH_ACCEL:  fin_spd = (curve_spd < SPEED_MIN) ? SPEED_MIN : curve_spd;
         PH_BRAKE:  fin_spd = curve_spd;
         PH_CRUISE: fin_spd = {tspeed_ff, 8'h00};
         default:   fin_spd = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      m_in         = m_ff;
      phase_in     = phase_ff;
      factor_in    = factor_ff;
      prod_in      = prod_ff;
      start_in     = start_ff;
      dist_in      = dist_ff;
      tspeed_in    = tspeed_ff;
      ramp_in      = ramp_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_phase_in = rsp_phase_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_take) begin
         case (csr_bus.index)
            CSR_START_POS: begin
               start_in = csr_bus.data;
               ramp_in  = '0;
               last_in  = '0;
            end
            CSR_MOVE_DIST: begin
               dist_in = csr_bus.data[DIST_W-1:0];
               ramp_in = '0;
               last_in = '0;
            end
            CSR_TARGET_SPD: begin
               tspeed_in = csr_bus.data[SPD_W-1:0];
               ramp_in   = '0;
               last_in   = '0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pos_in   = req_bus.position;
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            m_in     = delta[POS_W] ? POS_W'(-delta) : delta[POS_W-1:0];
            state_in = S_PHASE;
         end
         S_PHASE: begin
            if (m_ff >= {1'b0, dist_ff}) begin
               phase_in = PH_DONE;
               state_in = S_FIN;
            end else if (m_ff[DIST_W-1:0] < (dist_ff >> 1)) begin
               if (last_ff < {tspeed_ff, 8'h00}) begin
                  phase_in = PH_ACCEL;
                  state_in = S_ARG;
               end else begin
                  phase_in = PH_CRUISE;
                  state_in = S_FIN;
               end
            end else if ({1'b0, remain} <= ramp_ff) begin
               phase_in = PH_BRAKE;
               state_in = S_ARG;
            end else begin
               phase_in = PH_CRUISE;
               state_in = S_FIN;
            end
         end
         S_ARG: begin
            if (phase_ff == PH_ACCEL) begin
               ramp_in = m_ff;
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            factor_in = cos_add ? (FAC_W'(65536) + FAC_W'(cos_mag))
                                : (FAC_W'(65536) - FAC_W'(cos_mag));
            state_in  = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(tspeed_ff) * PROD_W'(factor_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = fin_spd;
               rsp_phase_in = phase_ff;
               last_in      = fin_spd;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         dist_ff      <= '0;
         tspeed_ff    <= '0;
         ramp_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         dist_ff      <= dist_in;
         tspeed_ff    <= tspeed_in;
         ramp_ff      <= ramp_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      m_ff         <= m_in;
      phase_ff     <= phase_in;
      factor_ff    <= factor_in;
      prod_ff      <= prod_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.speed_q8 = rsp_speed_ff;
   assign rsp_bus.phase    = rsp_phase_ff;

   sinr_div #(
      .SHIFT_W (SHIFT_W),
      .QUO_W   (QUO_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_arg),
      .divisor  (tspeed_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   sinr_cos_rom #(
      .DEPTH (COS_TABLE_DEPTH)
   ) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

endmodule

FILE: rtl/sinr_div.sv
// sinr_div: restoring serial divider, one quotient bit per cycle, keeps only
// the low quotient bits (the angle index modulo a full turn). depends on sinr_pkg.
`timescale 1ns / 1ps

module sinr_div #(
   parameter int SHIFT_W = 9,
   parameter int QUO_W   = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sinr_pkg::DIST_W-1:0]   dividend,
   input  logic [sinr_pkg::SPD_W-1:0]    divisor,
   output logic                          busy,
   output logic [QUO_W-1:0]              quotient
);
   import sinr_pkg::*;

   localparam int NUM_W = DIST_W + SHIFT_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [SPD_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [SPD_W:0]   trial;
   logic [SPD_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = {dividend, {SHIFT_W{1'b0}}};
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = ge ? diff[SPD_W-1:0] : trial[SPD_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/sinr_cos_rom.sv
// sinr_cos_rom: quarter-wave cosine table in Q0.16 with registered read,
// entries worked out at elaboration from a truncating Q2.30 series. depends on sinr_pkg.
`timescale 1ns / 1ps

module sinr_cos_rom #(
   parameter int DEPTH = 256
) (
   input  logic                        clock,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   output logic [sinr_pkg::COS_W-1:0]  data
);
   import sinr_pkg::*;

   logic [COS_W-1:0] rom_tab [DEPTH];
   logic [COS_W-1:0] data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic [63:0] XK = (PI_Q30 * 64'(k)) / 64'(2 * DEPTH);
      localparam logic [63:0] X2 = (XK * XK) >> 30;
      localparam logic [63:0] T1  = ((64'd1073741824 * X2) >> 30) / 64'd2;
      localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd12;
      localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd30;
      localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd56;
      localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd90;
      localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd132;
      localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd182;
      localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd240;
      localparam logic [63:0] T9  = ((T8 * X2) >> 30) / 64'd306;
      localparam logic [63:0] T10 = ((T9 * X2) >> 30) / 64'd380;
      localparam logic signed [63:0] SUM = 64'sd1073741824
         - $signed(T1) + $signed(T2) - $signed(T3) + $signed(T4) - $signed(T5)
         + $signed(T6) - $signed(T7) + $signed(T8) - $signed(T9) + $signed(T10);
      localparam logic [63:0] RND = (SUM < 0) ? 64'd0 : ((64'(SUM) + 64'd8192) >> 14);
      localparam logic [COS_W-1:0] VAL = (RND > 64'd65535) ? 16'hFFFF : COS_W'(RND);
      assign rom_tab[k] = VAL;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_tab[addr];
   end

   assign data = data_ff;

endmodule

FILE: tb/sinr_profile_checker.sv
// sinr_profile_checker: watches the position, speed and csr channels of the sine ramp
// motion profile block, predicts every speed/phase beat and compares it.
// depends on sinr_pkg and sinr_if.
`timescale 1ns / 1ps

module sinr_profile_checker #(
   parameter int COS_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   sinr_req_if  req_bus,
   sinr_rsp_if  rsp_bus,
   sinr_csr_if  csr_bus,
   output int   mismatches,
   output int   pending_results,
   output int   accel_seen,
   output int   cruise_seen,
   output int   brake_seen,
   output int   done_seen
);
   import sinr_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] speed_q8;
      phase_type        phase;
   } profile_beat_type;

   logic signed [POS_W-1:0] start_pos;
   logic [DIST_W-1:0]       move_dist;
   logic [SPD_W-1:0]        cruise_spd;
   logic [31:0]             ramp_len;
   logic [OUT_W-1:0]        prev_speed;
   logic [COS_W-1:0]        cos_rom [COS_DEPTH];
   profile_beat_type        expected_beats [$];

   // quarter-wave cosine in Q0.16 from a truncating Q2.30 taylor series
   initial begin : build_cos_rom
      longint unsigned x, x2, term, div, v;
      longint          sum;
      for (int k = 0; k < COS_DEPTH; k++) begin
         x = (PI_Q30 * 64'(k)) / (2 * COS_DEPTH);
         x2 = (x * x) >> 30;
         term = 64'd1 << 30;
         sum = longint'(term);
         for (int n = 1; n <= 10; n++) begin
            div = (2 * n - 1) * (2 * n);
            term = ((term * x2) >> 30) / div;
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (sum + 8192) >> 14;
         cos_rom[k] = (v > 65535) ? 16'hFFFF : 16'(v);
      end
   end

   // signed cos(pi*x/d) in Q0.16, angle index wraps every full period
   function automatic longint cos_q16(input longint unsigned x, input longint unsigned d);
      longint unsigned idx, quad, r;
      longint          s;
      if (d == 0) idx = 0;
      else idx = (x * 2 * COS_DEPTH) / d;
      idx = idx % (4 * COS_DEPTH);
      quad = idx / COS_DEPTH;
      r = idx % COS_DEPTH;
      s = (r == 0) ? 0 : longint'(cos_rom[COS_DEPTH - r]);
      case (quad)
         0:       return longint'(cos_rom[r]);
         1:       return -s;
         2:       return -longint'(cos_rom[r]);
         default: return s;
      endcase
   endfunction

   function automatic logic [OUT_W-1:0] curve_speed(input longint unsigned d,
                                                    input longint factor);
      longint unsigned v;
      v = (d * factor + 256) >> 9;
      return (v > SPEED_MAX) ? SPEED_MAX : OUT_W'(v);
   endfunction

   function automatic profile_beat_type advance_profile(input logic signed [POS_W-1:0] pos);
      longint           delta;
      longint unsigned  m, travel, d, b;
      profile_beat_type beat;
      delta = longint'(pos) - longint'(start_pos);
      m = (delta < 0) ? -delta : delta;
      travel = move_dist;
      d = cruise_spd;
      if (m >= travel) beat.phase = PH_DONE;
      else if (m < travel / 2) beat.phase = (prev_speed < (d << 8)) ? PH_ACCEL : PH_CRUISE;
      else beat.phase = (travel - m <= ramp_len) ? PH_BRAKE : PH_CRUISE;
      case (beat.phase)
         PH_ACCEL: begin
            beat.speed_q8 = curve_speed(d, 65536 - cos_q16(m, d));
            if (beat.speed_q8 < SPEED_MIN) beat.speed_q8 = SPEED_MIN;
            ramp_len = 32'(m);
         end
         PH_CRUISE: beat.speed_q8 = OUT_W'(d << 8);
         PH_BRAKE: begin
            // braking angle counts from where the ramp down begins
            b = m + ramp_len - travel;
            beat.speed_q8 = curve_speed(d, 65536 + cos_q16(b, d));
         end
         default: beat.speed_q8 = '0;
      endcase
      prev_speed = beat.speed_q8;
      return beat;
   endfunction

   always @(posedge clock) begin
      profile_beat_type got, want;
      logic             listed;
      if (reset) begin
         start_pos = '0;
         move_dist = '0;
         cruise_spd = '0;
         ramp_len = '0;
         prev_speed = '0;
         expected_beats.delete();
         mismatches = 0;
         accel_seen = 0;
         cruise_seen = 0;
         brake_seen = 0;
         done_seen = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            listed = 1'b1;
            case (csr_bus.index)
               CSR_START_POS:  start_pos = csr_bus.data;
               CSR_MOVE_DIST:  move_dist = csr_bus.data[DIST_W-1:0];
               CSR_TARGET_SPD: cruise_spd = csr_bus.data[SPD_W-1:0];
               default:        listed = 1'b0;
            endcase
            if (listed) begin
               ramp_len = '0;
               prev_speed = '0;
            end
         end
         // compare before queuing: a beat leaving now belongs to an earlier position
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.speed_q8 = rsp_bus.speed_q8;
            got.phase = rsp_bus.phase;
            if (expected_beats.size() == 0) begin
               $error("speed beat with no position pending: speed_q8 %0d phase %0d",
                      got.speed_q8, got.phase);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (got.speed_q8 !== want.speed_q8) begin
                  $error("speed_q8 mismatch: expected %0d, got %0d",
                         want.speed_q8, got.speed_q8);
                  mismatches++;
               end
               if (got.phase !== want.phase) begin
                  $error("phase mismatch: expected %0d, got %0d", want.phase, got.phase);
                  mismatches++;
               end
               case (want.phase)
                  PH_ACCEL:  accel_seen++;
                  PH_CRUISE: cruise_seen++;
                  PH_BRAKE:  brake_seen++;
                  default:   done_seen++;
               endcase
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_beats.push_back(advance_profile(req_bus.position));
      end
      pending_results = expected_beats.size();
   end

endmodule

FILE: tb/sine_ramp_motion_profile_test.sv
// sine_ramp_motion_profile_test: drives position beats, register writes and response
// back-pressure into the motion profile block and reports the verdict.
// depends on sinr_pkg, sinr_if, sine_ramp_motion_profile and sinr_profile_checker.
`timescale 1ns / 1ps

module sine_ramp_motion_profile_test;
   import sinr_pkg::*;

   localparam int COS_DEPTH = 256;
   localparam int RANDOM_BEATS = 1250;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam longint POS_MIN = -(64'sd1 <<< 31);
   localparam longint POS_MAX = (64'sd1 <<< 31) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int mismatches, pending_results;
   int accel_seen, cruise_seen, brake_seen, done_seen;
   int beats_sent = 0;
   int directed_beats = 0;
   int csr_writes = 0;
   bit pace_gaps = 1'b1;
   bit hold_rsp_request = 1'b0;

   longint cur_start = 0;
   longint cur_dist = 0;
   longint cur_speed = 0;

   sinr_req_if req_bus ();
   sinr_rsp_if rsp_bus ();
   sinr_csr_if csr_bus ();

   sine_ramp_motion_profile #(.COS_TABLE_DEPTH(COS_DEPTH)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sinr_profile_checker #(.COS_DEPTH(COS_DEPTH)) profile_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .accel_seen      (accel_seen),
      .cruise_seen     (cruise_seen),
      .brake_seen      (brake_seen),
      .done_seen       (done_seen)
   );

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      if (!pace_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : rsp_pacing
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = gap_len();
         end
      end
   end

   task automatic send_position(input logic signed [POS_W-1:0] pos);
      int gap;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.position <= $urandom;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait until every speed beat has come back
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      csr_writes++;
   endtask

   // unused upper data bits are filled with noise, the block must mask them
   task automatic set_profile(input longint start, input longint travel, input longint spd);
      settle();
      cur_start = start;
      cur_dist = travel;
      cur_speed = spd;
      csr_write(CSR_START_POS, 32'(start));
      csr_write(CSR_MOVE_DIST, {1'($urandom), 31'(travel)});
      csr_write(CSR_TARGET_SPD, {16'($urandom), 16'(spd)});
   endtask

   task automatic random_profile();
      longint travel, spd, start;
      case ($urandom_range(0, 9))
         0:       travel = $urandom_range(0, 3);
         1:       travel = POS_MAX;
         2, 3:    travel = $urandom_range(4, 2000);
         4, 5, 6: travel = $urandom_range(2000, 300000);
         default: travel = $urandom & 32'h7FFF_FFFF;
      endcase
      case ($urandom_range(0, 9))
         0: spd = 0;
         1: spd = 65535;
         2: spd = $urandom_range(1, 256);
         3: spd = $urandom_range(1, 65535);
         default: begin
            spd = travel / $urandom_range(2, 20);
            if (spd < 1) spd = 1;
            if (spd > 65535) spd = 65535;
         end
      endcase
      case ($urandom_range(0, 7))
         0:       start = POS_MIN;
         1:       start = POS_MAX;
         default: start = longint'($signed($urandom));
      endcase
      set_profile(start, travel, spd);
   endtask

   // walk away from the start past the full distance, with jitter and the odd step back
   task automatic run_move(input int steps, input bit pause_mid);
      longint span, stride, m, pos;
      int     dir;
      span = cur_dist + cur_dist / 8 + 2;
      stride = span / steps + 1;
      dir = $urandom_range(0, 1) ? 1 : -1;
      m = 0;
      for (int i = 0; i < steps; i++) begin
         pos = cur_start + dir * m;
         if (pos > POS_MAX || pos < POS_MIN) pos = cur_start - dir * m;
         if (pos > POS_MAX) pos = POS_MAX;
         else if (pos < POS_MIN) pos = POS_MIN;
         send_position(32'(pos));
         if (pause_mid && i == steps / 2) settle();
         if ($urandom_range(0, 19) == 0) m -= stride;
         else m += (stride * $urandom_range(50, 150)) / 100;
         if (m < 0) m = 0;
      end
   endtask

   initial begin : stimulus
      longint basic_move [8] = '{300, 450, 600, 850, 950, 999, 1000, -500};
      longint wrap_move [6] = '{0, 1500, 1073741822, 1073741823, 2147483000,
                                4294967295};
      longint stopped_move [3] = '{0, 55, 100};
      longint fast_move [4] = '{0, -65535, -1000000, -1990000};

      req_bus.valid = 1'b0;
      req_bus.position = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset: zero distance, so everything is done
      send_position(32'sd0);
      send_position(32'h7FFF_FFFF);
      send_position(32'h8000_0000);

      // slow target: ramp reaches cruise, then brake and done
      set_profile(0, 1000, 200);
      send_position(32'sd0);
      send_position(32'sd100);
      send_position(32'sd200);
      settle();
      // unmapped index must leave the recorded ramp alone
      csr_write(CSR_UNMAPPED, 32'hFFFF_FFFF);
      foreach (basic_move[i]) send_position(32'(cur_start + basic_move[i]));

      // full-range move with a long acceleration that wraps the cosine
      set_profile(POS_MIN, POS_MAX, 1000);
      foreach (wrap_move[i]) send_position(32'(cur_start + wrap_move[i]));

      // zero target speed never accelerates
      set_profile(5, 100, 0);
      foreach (stopped_move[i]) send_position(32'(cur_start + stopped_move[i]));

      set_profile(POS_MAX, 2000000, 65535);
      foreach (fast_move[i]) send_position(32'(cur_start + fast_move[i]));
      directed_beats = beats_sent;

      // receiver holds off while positions keep coming, sender later waits for drain
      random_profile();
      pace_gaps = 1'b0;
      hold_rsp_request = 1'b1;
      run_move(20, 1'b1);

      while (beats_sent < directed_beats + RANDOM_BEATS) begin
         pace_gaps = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 1)) send_position($urandom);
                  else send_position(32'(cur_start + longint'($urandom_range(0, 2000)) - 1000));
               end
            end
            1: begin
               settle();
               csr_write(CSR_UNMAPPED, $urandom);
               run_move($urandom_range(6, 30), $urandom_range(0, 5) == 0);
            end
            2: begin
               // new target on the same move, ramp state starts over
               settle();
               cur_speed = $urandom_range(0, 65535);
               csr_write(CSR_TARGET_SPD, {16'($urandom), 16'(cur_speed)});
               run_move($urandom_range(6, 30), $urandom_range(0, 5) == 0);
            end
            default: begin
               random_profile();
               run_move($urandom_range(8, 40), $urandom_range(0, 5) == 0);
            end
         endcase
      end

      settle();
      repeat (60) @(negedge clock);
      $display("covered %0d position beats (%0d directed) under %0d register writes",
               beats_sent, directed_beats, csr_writes);
      $display("speed beats by phase: accelerate %0d, cruise %0d, brake %0d, done %0d",
               accel_seen, cruise_seen, brake_seen, done_seen);
      if (mismatches == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sinr_pkg.sv
rtl/sinr_if.sv
rtl/sinr_div.sv
rtl/sinr_cos_rom.sv
rtl/sine_ramp_motion_profile.sv
tb/sinr_profile_checker.sv
tb/sine_ramp_motion_profile_test.sv
